### sv/slbc_pkg.sv
// Shared types, mode codes and register map for the status LED blink controller.
package slbc_pkg;

    localparam int unsigned NUM_LEDS   = 2;
    localparam int unsigned REG_WIDTH  = 16;
    localparam int unsigned NUM_REGS   = 8;
    localparam int unsigned REG_IDX_W  = 3;
    localparam int unsigned REGS_PER_LED = 4;

    localparam int unsigned IDX_GREEN = 0;
    localparam int unsigned IDX_RED   = 1;

    // Per-LED register offsets within a group of four
    localparam logic [1:0] OFS_SLOW_ON     = 2'd0;
    localparam logic [1:0] OFS_SLOW_PERIOD = 2'd1;
    localparam logic [1:0] OFS_FAST_ON     = 2'd2;
    localparam logic [1:0] OFS_FAST_PERIOD = 2'd3;

    localparam logic [REG_WIDTH-1:0] RST_SLOW_ON     = 16'd50;
    localparam logic [REG_WIDTH-1:0] RST_SLOW_PERIOD = 16'd100;
    localparam logic [REG_WIDTH-1:0] RST_FAST_ON     = 16'd10;
    localparam logic [REG_WIDTH-1:0] RST_FAST_PERIOD = 16'd20;

    // LED mode codes
    localparam logic [3:0] MODE_OFF     = 4'd0;
    localparam logic [3:0] MODE_ON      = 4'd1;
    localparam logic [3:0] MODE_SLOW    = 4'd2;
    localparam logic [3:0] MODE_SLOW_X1 = 4'd3;
    localparam logic [3:0] MODE_SLOW_X3 = 4'd5;
    localparam logic [3:0] MODE_FAST    = 4'd6;
    localparam logic [3:0] MODE_FAST_X1 = 4'd7;
    localparam logic [3:0] MODE_FAST_X3 = 4'd9;

    // System state codes
    localparam logic [2:0] ST_POWER_ON      = 3'd0;
    localparam logic [2:0] ST_INITED        = 3'd1;
    localparam logic [2:0] ST_WORKING       = 3'd2;
    localparam logic [2:0] ST_RECONNECT     = 3'd3;
    localparam logic [2:0] ST_POWER_OFF     = 3'd4;
    localparam logic [2:0] ST_UPDATE_FAILED = 3'd5;
    localparam logic [2:0] ST_UPDATE_OK     = 3'd6;
    localparam logic [2:0] ST_SHUTDOWN      = 3'd7;

    // Input word, first field in the highest bits
    typedef struct packed {
        logic [1:0] pad;
        logic [3:0] red_mode_value;
        logic       red_mode_write;
        logic [3:0] green_mode_value;
        logic       green_mode_write;
        logic [2:0] new_state;
        logic       state_write;
    } t_in_word;

    // Result word, first field in the highest bits
    typedef struct packed {
        logic [5:0] pad;
        logic [3:0] red_mode_now;
        logic [3:0] green_mode_now;
        logic       red_on;
        logic       green_on;
    } t_out_word;

    // Green mode picked by a system state change
    function automatic logic [3:0] state_to_mode(input logic [2:0] st);
        logic [3:0] m;
        case (st)
            ST_INITED:        m = MODE_SLOW;
            ST_WORKING:       m = MODE_ON;
            ST_RECONNECT:     m = MODE_FAST;
            ST_POWER_OFF:     m = MODE_FAST_X3;
            ST_UPDATE_FAILED: m = MODE_FAST_X3;
            ST_UPDATE_OK:     m = MODE_ON;
            default:          m = MODE_OFF;
        endcase
        return m;
    endfunction

endpackage

### sv/status_led_blink_controller_unit.sv
// Two-LED status blink controller: one tick per input word, one result word per tick.
// The result word is registered: the input register holds the accepted word, then the
//   tick logic writes state and the result register together.
// Throughput: one word per cycle while the result side keeps up; a stalled result word
//   holds the tick waiting in the input register, so at most two words are in flight.
// Reset: synchronous, active low; clears handshake state, LED state and loads the
//   default flash timing registers.
module status_led_blink_controller_unit
    import slbc_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Config write port, index = register number 0..7
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_idx,
    input  logic [REG_WIDTH-1:0] i_cfg_wdata,
    // Tick words in
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // [0] state_write, [3:1] new_state, [4] green_mode_write, [8:5] green_mode_value,
    // [9] red_mode_write, [13:10] red_mode_value, [15:14] zero
    input  logic [15:0]          i_s_axis_tdata,
    // Result words out
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // [0] green_on, [1] red_on, [5:2] green_mode_now, [9:6] red_mode_now, [15:10] zero
    output logic [15:0]          o_m_axis_tdata
);

    // Compare width: counter and timing registers are both zero-extended to this
    localparam int unsigned CMP_W = (COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH;

    // Timing registers, [led][offset]
    logic [REG_WIDTH-1:0] r_cfg [NUM_LEDS][REGS_PER_LED];

    // Input register
    logic     r_in_valid;
    t_in_word r_in;

    // Result register
    logic      r_out_valid;
    t_out_word r_out, n_out;

    // Tick state
    logic [2:0]             r_sys, n_sys;
    logic [2:0]             r_sys_prev, n_sys_prev;
    logic [3:0]             r_mode      [NUM_LEDS];
    logic [3:0]             n_mode      [NUM_LEDS];
    logic [3:0]             r_mode_prev [NUM_LEDS];
    logic [3:0]             n_mode_prev [NUM_LEDS];
    logic [COUNT_WIDTH-1:0] r_cnt       [NUM_LEDS];
    logic [COUNT_WIDTH-1:0] n_cnt       [NUM_LEDS];
    logic [1:0]             r_blinks    [NUM_LEDS];
    logic [1:0]             n_blinks    [NUM_LEDS];
    logic                   r_level     [NUM_LEDS];
    logic                   n_level     [NUM_LEDS];

    // A tick is processed when the input register is full and the result slot frees up
    logic advance;
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NUM_LEDS; l++) begin
                r_cfg[l][OFS_SLOW_ON]     <= RST_SLOW_ON;
                r_cfg[l][OFS_SLOW_PERIOD] <= RST_SLOW_PERIOD;
                r_cfg[l][OFS_FAST_ON]     <= RST_FAST_ON;
                r_cfg[l][OFS_FAST_PERIOD] <= RST_FAST_PERIOD;
            end
        end else if (i_cfg_we) begin
            // Top index bit picks the LED, low two bits the register in its group
            r_cfg[i_cfg_idx[REG_IDX_W-1]][i_cfg_idx[1:0]] <= i_cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in <= t_in_word'(i_s_axis_tdata);
        end
    end

    // Tick logic
    always_comb begin : tick
        logic [3:0]       m;
        logic             fast;
        logic             burst;
        logic [CMP_W-1:0] cnt_x;
        logic [CMP_W-1:0] on_x;
        logic [CMP_W-1:0] per_x;

        // System state record
        n_sys      = r_in.state_write ? r_in.new_state : r_sys;
        n_sys_prev = r_in.state_write ? r_sys : r_sys_prev;

        // Direct mode writes
        n_mode[IDX_GREEN] = r_in.green_mode_write ? r_in.green_mode_value : r_mode[IDX_GREEN];
        n_mode[IDX_RED]   = r_in.red_mode_write   ? r_in.red_mode_value   : r_mode[IDX_RED];

        // A fresh system state overrides the green mode; power-on and shutdown don't
        if (n_sys inside {[ST_INITED:ST_UPDATE_OK]} && n_sys != n_sys_prev) begin
            n_mode[IDX_GREEN] = state_to_mode(n_sys);
            n_sys_prev        = n_sys;
        end

        for (int l = 0; l < NUM_LEDS; l++) begin
            m              = n_mode[l];
            n_mode_prev[l] = r_mode_prev[l];
            n_cnt[l]       = r_cnt[l];
            n_blinks[l]    = r_blinks[l];
            n_level[l]     = r_level[l];
            cnt_x          = '0;
            fast           = (m >= MODE_FAST);
            burst          = (m != MODE_SLOW) && (m != MODE_FAST);
            on_x  = CMP_W'(fast ? r_cfg[l][OFS_FAST_ON]     : r_cfg[l][OFS_SLOW_ON]);
            per_x = CMP_W'(fast ? r_cfg[l][OFS_FAST_PERIOD] : r_cfg[l][OFS_SLOW_PERIOD]);

            if (m > MODE_FAST_X3) begin
                // Unknown code: drop to off, nothing else this tick
                n_mode[l] = MODE_OFF;
            end else begin
                // Mode entry
                if (m != r_mode_prev[l]) begin
                    n_mode_prev[l] = m;
                    n_cnt[l]       = '0;
                    if (m inside {[MODE_SLOW_X1:MODE_SLOW_X3]}) begin
                        n_blinks[l] = 2'(m - MODE_SLOW);
                    end else if (m inside {[MODE_FAST_X1:MODE_FAST_X3]}) begin
                        n_blinks[l] = 2'(m - MODE_FAST);
                    end
                end

                cnt_x = CMP_W'(n_cnt[l]);
                if (m == MODE_OFF) begin
                    n_level[l] = 1'b0;
                end else if (m == MODE_ON) begin
                    n_level[l] = 1'b1;
                end else if (cnt_x == '0) begin
                    n_level[l] = 1'b1;
                    n_cnt[l]   = n_cnt[l] + 1'b1;
                end else if (cnt_x == on_x) begin
                    n_level[l] = 1'b0;
                    n_cnt[l]   = n_cnt[l] + 1'b1;
                end else if (cnt_x >= per_x) begin
                    // Period wrap; a burst counts down and ends in off
                    n_cnt[l] = '0;
                    if (burst) begin
                        n_blinks[l] = n_blinks[l] - 2'd1;
                        if (n_blinks[l] == 2'd0) begin
                            n_mode[l] = MODE_OFF;
                        end
                    end
                end else begin
                    n_cnt[l] = n_cnt[l] + 1'b1;
                end
            end
        end

        n_out                = '0;
        n_out.green_on       = n_level[IDX_GREEN];
        n_out.red_on         = n_level[IDX_RED];
        n_out.green_mode_now = n_mode[IDX_GREEN];
        n_out.red_mode_now   = n_mode[IDX_RED];
    end

    // State and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sys       <= ST_POWER_ON;
            r_sys_prev  <= ST_POWER_ON;
            r_out_valid <= 1'b0;
            for (int l = 0; l < NUM_LEDS; l++) begin
                r_cnt[l]    <= '0;
                r_blinks[l] <= '0;
                r_level[l]  <= 1'b0;
            end
            r_mode[IDX_GREEN]      <= MODE_OFF;
            r_mode[IDX_RED]        <= MODE_ON;
            r_mode_prev[IDX_GREEN] <= MODE_OFF;
            r_mode_prev[IDX_RED]   <= MODE_ON;
        end else begin
            if (advance) begin
                r_sys       <= n_sys;
                r_sys_prev  <= n_sys_prev;
                r_out_valid <= 1'b1;
                for (int l = 0; l < NUM_LEDS; l++) begin
                    r_mode[l]      <= n_mode[l];
                    r_mode_prev[l] <= n_mode_prev[l];
                    r_cnt[l]       <= n_cnt[l];
                    r_blinks[l]    <= n_blinks[l];
                    r_level[l]     <= n_level[l];
                end
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

### sv/slbc_checker.sv
// Port-level checker for the status LED blink controller, bound to the top level.
module slbc_checker
    import slbc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata
);

    t_out_word w;
    assign w = t_out_word'(o_m_axis_tdata);

    // Stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result word changed while stalled");

    // With the result slot empty the input side must be open
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty result slot");

    // Unknown mode codes never survive a tick
    a_mode_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> w.green_mode_now <= MODE_FAST_X3 && w.red_mode_now <= MODE_FAST_X3)
        else $error("unknown LED mode reported");

    // Steady-on mode always drives the LED
    a_on_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w.green_mode_now != MODE_ON || w.green_on)
                         && (w.red_mode_now != MODE_ON || w.red_on))
        else $error("LED in on mode not driven");

endmodule

bind status_led_blink_controller_unit slbc_checker u_slbc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

### test/tb_status_led_blink_controller_unit.sv
// Self-checking testbench for the status LED blink controller, driven by directed and random ticks.
module tb_status_led_blink_controller_unit
    import slbc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned COUNT_W = 16;

    // Mode codes the package does not name
    localparam logic [3:0] MODE_SLOW_X2   = 4'd4;
    localparam logic [3:0] MODE_FAST_X2   = 4'd8;
    localparam logic [3:0] MODE_UNKNOWN_LO = 4'd10;
    localparam logic [3:0] MODE_UNKNOWN_HI = 4'd15;

    // Receiver stall styles, one picked at random whenever the receiver's counter wraps its low six bits
    typedef enum int {
        RDY_ALWAYS,
        RDY_SKIP_ONE,
        RDY_SPARSE,
        RDY_RANDOM
    } t_rdy_style;

    // ------------------------------------------------------------------
    // DUT connections; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [REG_IDX_W-1:0] cfg_idx  = '0;
    logic [REG_WIDTH-1:0] cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b1;
    logic [15:0]          m_tdata;

    status_led_blink_controller_unit #(
        .COUNT_WIDTH(COUNT_W)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the controller
    // ------------------------------------------------------------------
    logic [REG_WIDTH-1:0] timing      [NUM_REGS];
    logic [REG_WIDTH-1:0] next_timing [NUM_REGS];
    logic [2:0]           cur_state;
    logic [2:0]           last_state;
    logic [3:0]           mode_q     [NUM_LEDS];
    logic [3:0]           mode_seen  [NUM_LEDS];   // mode on the previous tick
    logic [COUNT_W-1:0]   flash_cnt  [NUM_LEDS];
    logic [1:0]           blinks     [NUM_LEDS];
    logic                 led_lvl    [NUM_LEDS];

    t_in_word  pending_ticks[$];     // words waiting for the driver
    t_out_word expected_leds[$];     // predicted result words, oldest first

    int unsigned ticks_queued   = 0;
    int unsigned ticks_accepted = 0;
    int unsigned words_checked  = 0;
    int unsigned mismatches     = 0;

    // One flash/burst step of a single LED
    function automatic void step_led(int unsigned led);
        logic [3:0]           m;
        logic [REG_WIDTH-1:0] on_t;
        logic [REG_WIDTH-1:0] per;
        logic                 fast;
        logic                 in_burst;
        int unsigned          base;
        m = mode_q[led];
        if (m > MODE_FAST_X3) begin
            // unknown code: forced off, nothing else this tick
            mode_q[led] = MODE_OFF;
            return;
        end
        if (m != mode_seen[led]) begin
            mode_seen[led] = m;
            flash_cnt[led] = '0;
            if (m >= MODE_SLOW_X1 && m <= MODE_SLOW_X3) blinks[led] = 2'(m - MODE_SLOW);
            if (m >= MODE_FAST_X1 && m <= MODE_FAST_X3) blinks[led] = 2'(m - MODE_FAST);
        end
        if (m == MODE_OFF) begin
            led_lvl[led] = 1'b0;
            return;
        end
        if (m == MODE_ON) begin
            led_lvl[led] = 1'b1;
            return;
        end
        fast     = (m >= MODE_FAST);
        in_burst = (m != MODE_SLOW) && (m != MODE_FAST);
        base     = led * REGS_PER_LED;
        on_t     = timing[base + (fast ? OFS_FAST_ON : OFS_SLOW_ON)];
        per      = timing[base + (fast ? OFS_FAST_PERIOD : OFS_SLOW_PERIOD)];
        if (flash_cnt[led] == '0) begin
            led_lvl[led] = 1'b1;
        end else if (flash_cnt[led] == on_t) begin
            led_lvl[led] = 1'b0;
        end else if (flash_cnt[led] >= per) begin
            flash_cnt[led] = '0;
            if (in_burst) begin
                blinks[led] = blinks[led] - 2'd1;   // wraps 0 -> 3
                if (blinks[led] == 2'd0) mode_q[led] = MODE_OFF;
            end
            return;
        end
        flash_cnt[led] = flash_cnt[led] + 1'b1;
    endfunction

    // Apply one tick word and return the LED word it should produce
    function automatic t_out_word predict_tick(t_in_word w);
        t_out_word r;
        if (w.state_write) begin
            last_state = cur_state;
            cur_state  = w.new_state;
        end
        if (w.green_mode_write) mode_q[IDX_GREEN] = w.green_mode_value;
        if (w.red_mode_write)   mode_q[IDX_RED]   = w.red_mode_value;
        // a new system state overrides any green write in the same tick
        if (cur_state != ST_POWER_ON && cur_state != ST_SHUTDOWN && cur_state != last_state) begin
            case (cur_state)
                ST_INITED:                mode_q[IDX_GREEN] = MODE_SLOW;
                ST_WORKING, ST_UPDATE_OK: mode_q[IDX_GREEN] = MODE_ON;
                ST_RECONNECT:             mode_q[IDX_GREEN] = MODE_FAST;
                default:                  mode_q[IDX_GREEN] = MODE_FAST_X3;
            endcase
            last_state = cur_state;
        end
        step_led(IDX_GREEN);
        step_led(IDX_RED);
        r                = '0;
        r.green_on       = led_lvl[IDX_GREEN];
        r.red_on         = led_lvl[IDX_RED];
        r.green_mode_now = mode_q[IDX_GREEN];
        r.red_mode_now   = mode_q[IDX_RED];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (mismatches < 30)
            $display("[%0t] word %0d %s: got %0d, want %0d", $realtime, words_checked,
                     what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of words with random gaps, fed from pending_ticks.
    // Prediction happens at the accepting edge so state order matches the DUT.
    // ------------------------------------------------------------------
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_leds.push_back(predict_tick(s_tdata));
                ticks_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0 || pending_ticks.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    s_tvalid <= 1'b0;
                end else begin
                    s_tdata  <= pending_ticks.pop_front();
                    s_tvalid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        // a third of the bursts run back to back with no gap
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver back-pressure: a style is picked at random each time the low six bits wrap on a counter of clock cycles
    // ------------------------------------------------------------------
    t_rdy_style  rdy_style = RDY_ALWAYS;
    logic [15:0] rdy_cyc   = '0;

    always @(posedge clk) begin
        rdy_cyc = rdy_cyc + 1'b1;
        if (rdy_cyc[5:0] == 6'd0) rdy_style = t_rdy_style'($urandom_range(0, 3));
        case (rdy_style)
            RDY_ALWAYS:   m_tready <= 1'b1;
            RDY_SKIP_ONE: m_tready <= (rdy_cyc[1:0] != 2'd3);
            RDY_SPARSE:   m_tready <= (rdy_cyc[2:0] < 3'd2);
            default:      m_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    // ------------------------------------------------------------------
    // Monitor: every accepted result word against the oldest prediction
    // ------------------------------------------------------------------
    t_out_word got_word;
    t_out_word want_word;

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            got_word = m_tdata;
            if (expected_leds.size() == 0) begin
                report_mismatch("word with nothing pending", m_tdata, 0);
            end else begin
                want_word = expected_leds.pop_front();
                if (got_word.green_on !== want_word.green_on)
                    report_mismatch("green_on", got_word.green_on, want_word.green_on);
                if (got_word.red_on !== want_word.red_on)
                    report_mismatch("red_on", got_word.red_on, want_word.red_on);
                if (got_word.green_mode_now !== want_word.green_mode_now)
                    report_mismatch("green_mode_now", got_word.green_mode_now,
                                    want_word.green_mode_now);
                if (got_word.red_mode_now !== want_word.red_mode_now)
                    report_mismatch("red_mode_now", got_word.red_mode_now,
                                    want_word.red_mode_now);
            end
            words_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_tick(logic sw, logic [2:0] st, logic gw, logic [3:0] gm,
                                       logic rw, logic [3:0] rm);
        t_in_word w;
        w                  = '0;
        w.state_write      = sw;
        w.new_state        = st;
        w.green_mode_write = gw;
        w.green_mode_value = gm;
        w.red_mode_write   = rw;
        w.red_mode_value   = rm;
        pending_ticks.push_back(w);
        ticks_queued++;
    endfunction

    // Mostly plain ticks so flashes and bursts run to completion; now and then
    // a state change or a mode write, sometimes with an unknown mode code.
    function automatic void queue_random(int unsigned n);
        logic [3:0] gm;
        logic [3:0] rm;
        for (int unsigned k = 0; k < n; k++) begin
            gm = 4'($urandom_range(MODE_OFF, MODE_FAST_X3));
            if ($urandom_range(0, 7) == 0)
                gm = 4'($urandom_range(MODE_UNKNOWN_LO, MODE_UNKNOWN_HI));
            rm = 4'($urandom_range(MODE_OFF, MODE_FAST_X3));
            if ($urandom_range(0, 7) == 0)
                rm = 4'($urandom_range(MODE_UNKNOWN_LO, MODE_UNKNOWN_HI));
            queue_tick($urandom_range(0, 15) == 0, 3'($urandom_range(ST_POWER_ON, ST_SHUTDOWN)),
                       $urandom_range(0, 15) == 0, gm,
                       $urandom_range(0, 15) == 0, rm);
        end
    endfunction

    function automatic void plan_led_timing(int unsigned led, int unsigned slow_on,
                                            int unsigned slow_per, int unsigned fast_on,
                                            int unsigned fast_per);
        next_timing[led * REGS_PER_LED + OFS_SLOW_ON]     = REG_WIDTH'(slow_on);
        next_timing[led * REGS_PER_LED + OFS_SLOW_PERIOD] = REG_WIDTH'(slow_per);
        next_timing[led * REGS_PER_LED + OFS_FAST_ON]     = REG_WIDTH'(fast_on);
        next_timing[led * REGS_PER_LED + OFS_FAST_PERIOD] = REG_WIDTH'(fast_per);
    endfunction

    // Small random timing so bursts finish within a few dozen ticks;
    // on-counts at or above the period come up too.
    function automatic void plan_random_timing();
        for (int unsigned led = 0; led < NUM_LEDS; led++)
            plan_led_timing(led, $urandom_range(1, 5), $urandom_range(2, 8),
                            $urandom_range(1, 5), $urandom_range(2, 8));
    endfunction

    // Write all eight timing registers; only called while the DUT is idle
    task automatic load_timing();
        for (int unsigned idx = 0; idx < NUM_REGS; idx++) begin
            @(posedge clk);
            cfg_we      <= 1'b1;
            cfg_idx     <= idx[REG_IDX_W-1:0];
            cfg_wdata   <= next_timing[idx];
            timing[idx]  = next_timing[idx];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold off until every queued word is accepted and every result is back
    task automatic wait_for_results();
        int unsigned spin;
        spin = 0;
        while ((ticks_accepted != ticks_queued || expected_leds.size() != 0) && spin < 20000)
        begin
            @(posedge clk);
            spin++;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // predictor reset state
        for (int unsigned led = 0; led < NUM_LEDS; led++)
            plan_led_timing(led, RST_SLOW_ON, RST_SLOW_PERIOD, RST_FAST_ON, RST_FAST_PERIOD);
        for (int unsigned idx = 0; idx < NUM_REGS; idx++) timing[idx] = next_timing[idx];
        cur_state  = ST_POWER_ON;
        last_state = ST_POWER_ON;
        for (int unsigned led = 0; led < NUM_LEDS; led++) begin
            mode_q[led]    = (led == IDX_RED) ? MODE_ON : MODE_OFF;
            mode_seen[led] = mode_q[led];
            flash_cnt[led] = '0;
            blinks[led]    = '0;
            led_lvl[led]   = 1'b0;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // --- reset timing: idle tick, unknown codes, every system state ---
        queue_tick(1'b0, ST_POWER_ON, 1'b0, MODE_OFF, 1'b0, MODE_OFF);
        queue_tick(1'b0, ST_SHUTDOWN, 1'b1, MODE_UNKNOWN_HI, 1'b1, MODE_UNKNOWN_LO);
        // state change wins over the green write in the same tick
        queue_tick(1'b1, ST_INITED, 1'b1, MODE_ON, 1'b0, MODE_OFF);
        queue_tick(1'b1, ST_WORKING, 1'b0, MODE_OFF, 1'b0, MODE_OFF);
        queue_tick(1'b1, ST_RECONNECT, 1'b0, MODE_OFF, 1'b0, MODE_OFF);
        queue_tick(1'b1, ST_POWER_OFF, 1'b0, MODE_OFF, 1'b0, MODE_OFF);
        queue_tick(1'b1, ST_UPDATE_FAILED, 1'b0, MODE_OFF, 1'b0, MODE_OFF);
        queue_tick(1'b1, ST_UPDATE_OK, 1'b0, MODE_OFF, 1'b0, MODE_OFF);
        queue_tick(1'b1, ST_SHUTDOWN, 1'b0, MODE_OFF, 1'b0, MODE_OFF);
        queue_tick(1'b1, ST_POWER_ON, 1'b0, MODE_OFF, 1'b0, MODE_OFF);
        wait_for_results();

        // --- shortest legal timing: on 1, period 2 on both LEDs ---
        for (int unsigned led = 0; led < NUM_LEDS; led++) plan_led_timing(led, 1, 2, 1, 2);
        load_timing();
        queue_tick(1'b0, ST_POWER_ON, 1'b1, MODE_FAST_X1, 1'b1, MODE_SLOW);
        queue_tick(1'b0, ST_POWER_ON, 1'b0, MODE_OFF, 1'b0, MODE_OFF);
        queue_tick(1'b0, ST_POWER_ON, 1'b0, MODE_OFF, 1'b0, MODE_OFF);   // burst ends
        // burst code written back before the LED noticed the change: no reload,
        // the blink counter wraps and three more blinks follow
        queue_tick(1'b0, ST_POWER_ON, 1'b1, MODE_FAST_X1, 1'b0, MODE_OFF);
        queue_tick(1'b0, ST_POWER_ON, 1'b0, MODE_OFF, 1'b0, MODE_OFF);
        queue_tick(1'b0, ST_POWER_ON, 1'b0, MODE_OFF, 1'b0, MODE_OFF);
        queue_tick(1'b0, ST_POWER_ON, 1'b0, MODE_OFF, 1'b0, MODE_OFF);
        queue_tick(1'b0, ST_POWER_ON, 1'b1, MODE_SLOW_X3, 1'b1, MODE_SLOW_X1);
        queue_tick(1'b0, ST_POWER_ON, 1'b0, MODE_OFF, 1'b1, MODE_FAST);
        queue_tick(1'b0, ST_POWER_ON, 1'b1, MODE_SLOW_X2, 1'b1, MODE_FAST_X3);
        queue_tick(1'b0, ST_POWER_ON, 1'b1, MODE_SLOW_X1, 1'b1, MODE_FAST_X2);
        // every input field bit high; the pad bits stay zero
        queue_tick(1'b1, ST_SHUTDOWN, 1'b1, MODE_UNKNOWN_HI, 1'b1, MODE_UNKNOWN_HI);
        queue_tick(1'b1, ST_INITED, 1'b0, MODE_OFF, 1'b1, MODE_ON);
        queue_random(150);
        wait_for_results();

        // --- several random small timings ---
        for (int unsigned ph = 0; ph < 5; ph++) begin
            plan_random_timing();
            load_timing();
            queue_random(100);
            wait_for_results();
        end

        // --- top of the register range, plus on-count above and equal to period ---
        plan_led_timing(IDX_GREEN, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF);
        plan_led_timing(IDX_RED, 16'hFFFE, 3, 4, 4);
        load_timing();
        queue_random(60);
        wait_for_results();

        // wait a little longer for anything the DUT might still emit
        repeat (8) @(posedge clk);
        if (expected_leds.size() != 0)
            report_mismatch("results never delivered", expected_leds.size(), 0);

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
